### hw/rtl/foa_rot_pkg.sv
package foa_rot_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 16;
    localparam int FADE_BITS       = 16;
    localparam int FADE_ONE        = 32768;
    localparam int NUM_COEF        = 9;
    localparam int IDX_BITS        = 4;
    localparam int CMD_BITS        = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BEGIN  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                wr_en;
        logic                copy;
        logic [IDX_BITS-1:0] wr_idx;
        logic [IDX_BITS-1:0] rd_idx;
    } t_bank_ctl;

endpackage

### hw/rtl/foa_rot_coef_bank.sv
module foa_rot_coef_bank
    import foa_rot_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_bank_ctl                   i_ctl,
    input  logic signed [COEF_BITS-1:0] i_wr_data,
    output logic signed [COEF_BITS-1:0] o_rd_cur,
    output logic signed [COEF_BITS-1:0] o_rd_prev
);

    logic signed [COEF_BITS-1:0] r_cur  [NUM_COEF];
    logic signed [COEF_BITS-1:0] r_prev [NUM_COEF];
    logic signed [COEF_BITS-1:0] r_rd_cur;
    logic signed [COEF_BITS-1:0] r_rd_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_cur[i]  <= '0;
                r_prev[i] <= '0;
            end
        end else begin
            if (i_ctl.wr_en) begin
                r_cur[i_ctl.wr_idx] <= i_wr_data;
            end
            if (i_ctl.copy) begin
                for (int i = 0; i < NUM_COEF; i++) begin
                    r_prev[i] <= r_cur[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_cur  <= r_cur[i_ctl.rd_idx];
        r_rd_prev <= r_prev[i_ctl.rd_idx];
    end

    assign o_rd_cur  = r_rd_cur;
    assign o_rd_prev = r_rd_prev;

endmodule

### hw/rtl/foa_rot_mult.sv
module foa_rot_mult
    import foa_rot_pkg::*;
#(
    parameter int A_BITS = COEF_BITS_DEF + 1,
    parameter int B_BITS = SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic signed [A_BITS-1:0]        i_a,
    input  logic signed [B_BITS-1:0]        i_b,
    output logic signed [A_BITS+B_BITS-1:0] o_prod
);

    logic signed [A_BITS+B_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/foa_rotation_crossfade.sv
// A sample transfer steps through fetch, blend, round, multiply and accumulate states
// per coefficient and a row state per row; the done state registers the result once
// the output register is free, and ready stays low until then. One shared registered
// multiplier is used twice per coefficient (blend, then scale) over nine coefficients.
// Load, begin and end frame transfers complete in idle. Synchronous active-low reset
// clears both matrices, sets the first-frame flag and empties the output register.
module foa_rotation_crossfade
    import foa_rot_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF,
    localparam int W_LO          = IDX_BITS + COEF_BITS,
    localparam int F_LO          = W_LO + 4 * SAMPLE_BITS,
    localparam int IN_DATA_BITS  = ((F_LO + FADE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // coef_index, coef_value, in_w, in_y, in_z, in_x, fade, zero fill
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // command
    input  logic [CMD_BITS-1:0]      s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_w, out_y, out_z, out_x, zero fill
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    localparam int A_BITS     = COEF_BITS + 1;
    localparam int B_BITS     = (SAMPLE_BITS > FADE_BITS + 1) ? SAMPLE_BITS : FADE_BITS + 1;
    localparam int P_BITS     = A_BITS + B_BITS;
    localparam int BL_BITS    = P_BITS + 1;
    localparam int ACC_BITS   = P_BITS + 2;
    localparam int FRAC_SHIFT = FADE_BITS - 1;
    localparam int ROW_SHIFT  = COEF_BITS - 2;
    localparam int CV_LO      = IDX_BITS;
    localparam int Y_LO       = W_LO + SAMPLE_BITS;
    localparam int Z_LO       = W_LO + 2 * SAMPLE_BITS;
    localparam int X_LO       = W_LO + 3 * SAMPLE_BITS;

    localparam logic signed [BL_BITS-1:0]  BL_HALF  = BL_BITS'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(1) << (ROW_SHIFT - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MAX  =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_MIN  =
        {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [FADE_BITS-1:0]       FADE_MAX = FADE_BITS'(FADE_ONE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_BLEND,
        S_ROUND,
        S_MUL,
        S_ACC,
        S_ROW,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic                          r_first;
    logic [1:0]                    r_row;
    logic [1:0]                    r_col;
    logic signed [SAMPLE_BITS-1:0] r_w;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [SAMPLE_BITS-1:0] r_z;
    logic [FADE_BITS-1:0]          r_fade;
    logic signed [A_BITS-1:0]      r_b;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [SAMPLE_BITS-1:0] r_res [3];
    logic                          r_ovalid;
    logic [OUT_DATA_BITS-1:0]      r_odata;

    logic                          w_accept;
    t_cmd                          w_cmd;
    logic [IDX_BITS-1:0]           w_idx;
    logic [FADE_BITS-1:0]          w_fade;
    t_bank_ctl                     w_ctl;
    logic signed [COEF_BITS-1:0]   w_cur;
    logic signed [COEF_BITS-1:0]   w_prev;
    logic signed [A_BITS-1:0]      w_op_a;
    logic signed [B_BITS-1:0]      w_op_b;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic signed [P_BITS-1:0]      w_prod;
    logic signed [BL_BITS-1:0]     w_bsum;
    logic signed [ACC_BITS-1:0]    w_rnd;
    logic signed [ACC_BITS-1:0]    w_sh;
    logic signed [ACC_BITS-1:0]    w_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = t_cmd'(s_axis_tuser);
    assign w_idx         = s_axis_tdata[IDX_BITS-1:0];
    assign w_fade        = (s_axis_tdata[F_LO +: FADE_BITS] > FADE_MAX) ?
                           FADE_MAX : s_axis_tdata[F_LO +: FADE_BITS];

    always_comb begin
        w_ctl.wr_en  = w_accept && (w_cmd == CMD_LOAD) && (w_idx < IDX_BITS'(NUM_COEF));
        w_ctl.copy   = w_accept && (((w_cmd == CMD_BEGIN) && r_first) || (w_cmd == CMD_END));
        w_ctl.wr_idx = w_idx;
        w_ctl.rd_idx = IDX_BITS'({r_row, 1'b0}) + IDX_BITS'(r_row) + IDX_BITS'(r_col);
    end

    foa_rot_coef_bank #(
        .COEF_BITS (COEF_BITS)
    ) u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_data (s_axis_tdata[CV_LO +: COEF_BITS]),
        .o_rd_cur  (w_cur),
        .o_rd_prev (w_prev)
    );

    always_comb begin
        case (r_col)
            2'd0:    w_sample = r_x;
            2'd1:    w_sample = r_y;
            default: w_sample = r_z;
        endcase
    end

    // The blend is rewritten as prev * 1.0 + (cur - prev) * fade, so it needs one product.
    always_comb begin
        if (r_state == S_MUL) begin
            w_op_a = r_b;
            w_op_b = B_BITS'(w_sample);
        end else begin
            w_op_a = A_BITS'(w_cur) - A_BITS'(w_prev);
            w_op_b = B_BITS'({1'b0, r_fade});
        end
    end

    foa_rot_mult #(
        .A_BITS (A_BITS),
        .B_BITS (B_BITS)
    ) u_mult (
        .i_clk  (i_clk),
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_prod (w_prod)
    );

    assign w_bsum = BL_BITS'(w_prod) + (BL_BITS'(w_prev) <<< FRAC_SHIFT) + BL_HALF;
    assign w_rnd  = r_acc + ACC_HALF;
    assign w_sh   = w_rnd >>> ROW_SHIFT;
    assign w_sat  = (w_sh > SAT_MAX) ? SAT_MAX : ((w_sh < SAT_MIN) ? SAT_MIN : w_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_first  <= 1'b1;
            r_row    <= 2'd0;
            r_col    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_cmd == CMD_BEGIN) begin
                            r_first <= 1'b0;
                        end
                        if (w_cmd == CMD_SAMPLE) begin
                            r_w     <= s_axis_tdata[W_LO +: SAMPLE_BITS];
                            r_y     <= s_axis_tdata[Y_LO +: SAMPLE_BITS];
                            r_z     <= s_axis_tdata[Z_LO +: SAMPLE_BITS];
                            r_x     <= s_axis_tdata[X_LO +: SAMPLE_BITS];
                            r_fade  <= w_fade;
                            r_row   <= 2'd0;
                            r_col   <= 2'd0;
                            r_acc   <= '0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_b     <= w_bsum[COEF_BITS+FRAC_SHIFT:FRAC_SHIFT];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + ACC_BITS'(w_prod);
                    if (r_col == 2'd2) begin
                        r_col   <= 2'd0;
                        r_state <= S_ROW;
                    end else begin
                        r_col   <= r_col + 2'd1;
                        r_state <= S_FETCH;
                    end
                end
                S_ROW: begin
                    r_res[r_row] <= SAMPLE_BITS'(w_sat);
                    r_acc        <= '0;
                    if (r_row == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= S_FETCH;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= OUT_DATA_BITS'({r_res[2], r_res[1], r_res[0], r_w});
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_SAMPLE)) |=> !s_axis_tready)
        else $error("Ready stayed high after a sample transfer.");

    a_ctrl_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd != CMD_SAMPLE)) |=> s_axis_tready)
        else $error("A control transfer did not complete in one cycle.");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("A result appeared without a finished sample.");

    a_all_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((r_row == 2'd2) && (r_col == 2'd0)))
        else $error("A sample finished before all three rows were computed.");

endmodule

### sim/foa_rot_checker.sv
`timescale 1ns / 1ps

module foa_rot_checker
    import foa_rot_pkg::*;
#(
    parameter int IN_BITS  = ((IDX_BITS + COEF_BITS_DEF + 4 * SAMPLE_BITS_DEF + FADE_BITS + 7)
                              / 8) * 8,
    parameter int OUT_BITS = ((4 * SAMPLE_BITS_DEF + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [IN_BITS-1:0]  i_s_tdata,
    input  logic [CMD_BITS-1:0] i_s_tuser,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [OUT_BITS-1:0] i_m_tdata,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results
);

    localparam int SB   = SAMPLE_BITS_DEF;
    localparam int CB   = COEF_BITS_DEF;
    localparam int W_LO = IDX_BITS + CB;
    localparam int F_LO = W_LO + 4 * SB;
    localparam longint SAT_HI = (64'sd1 <<< (SB - 1)) - 1;
    localparam longint SAT_LO = -(64'sd1 <<< (SB - 1));

    logic signed [CB-1:0] cur_coef  [NUM_COEF] = '{default: '0};
    logic signed [CB-1:0] prev_coef [NUM_COEF] = '{default: '0};
    logic                 first_frame = 1'b1;
    logic [OUT_BITS-1:0]  rotated_q [$];
    string                field_name [4] = '{"out_w", "out_y", "out_z", "out_x"};
    int                   mismatches = 0;
    int                   samples_in = 0;
    int                   results_out = 0;

    function automatic longint blend_coef(int k, longint f);
        longint b;
        b = longint'(cur_coef[k]) * f + longint'(prev_coef[k]) * (FADE_ONE - f);
        return (b + (64'sd1 <<< 14)) >>> 15;
    endfunction

    function automatic logic [SB-1:0] rotate_row(int row, longint f, longint vx, longint vy,
                                                 longint vz);
        longint s;
        s = blend_coef(row * 3, f) * vx + blend_coef(row * 3 + 1, f) * vy
          + blend_coef(row * 3 + 2, f) * vz;
        s = (s + (64'sd1 <<< (CB - 3))) >>> (CB - 2);
        if (s > SAT_HI) s = SAT_HI;
        if (s < SAT_LO) s = SAT_LO;
        return s[SB-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] rotate_sample(logic [IN_BITS-1:0] d);
        longint f;
        longint vx;
        longint vy;
        longint vz;
        logic [OUT_BITS-1:0] r;
        f = longint'(d[F_LO +: FADE_BITS]);
        if (f > FADE_ONE) f = FADE_ONE;
        vy = longint'($signed(d[W_LO + SB +: SB]));
        vz = longint'($signed(d[W_LO + 2 * SB +: SB]));
        vx = longint'($signed(d[W_LO + 3 * SB +: SB]));
        r = '0;
        r[0 +: SB]      = d[W_LO +: SB];
        r[SB +: SB]     = rotate_row(0, f, vx, vy, vz);
        r[2 * SB +: SB] = rotate_row(1, f, vx, vy, vz);
        r[3 * SB +: SB] = rotate_row(2, f, vx, vy, vz);
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_BITS-1:0] want;
        logic [IDX_BITS-1:0] idx;
        if (!i_rst_n) begin
            cur_coef    = '{default: '0};
            prev_coef   = '{default: '0};
            first_frame = 1'b1;
            rotated_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results_out++;
                if (rotated_q.size() == 0) begin
                    $display("%0t: result with none expected, expected none, got %h",
                             $time, i_m_tdata);
                    mismatches++;
                end else begin
                    want = rotated_q.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (i_m_tdata[k * SB +: SB] !== want[k * SB +: SB]) begin
                            $display("%0t: %s expected %h got %h", $time, field_name[k],
                                     want[k * SB +: SB], i_m_tdata[k * SB +: SB]);
                            mismatches++;
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                idx = i_s_tdata[IDX_BITS-1:0];
                case (t_cmd'(i_s_tuser))
                    CMD_LOAD: begin
                        if (idx < NUM_COEF) cur_coef[idx] = i_s_tdata[IDX_BITS +: CB];
                    end
                    CMD_BEGIN: begin
                        if (first_frame) begin
                            prev_coef   = cur_coef;
                            first_frame = 1'b0;
                        end
                    end
                    CMD_SAMPLE: begin
                        rotated_q.push_back(rotate_sample(i_s_tdata));
                        samples_in++;
                    end
                    CMD_END: begin
                        prev_coef = cur_coef;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_errors  <= mismatches;
        o_pending <= samples_in - results_out;
        o_results <= results_out;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import foa_rot_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int CB           = COEF_BITS_DEF;
    localparam int W_LO         = IDX_BITS + CB;
    localparam int F_LO         = W_LO + 4 * SB;
    localparam int IN_BITS      = ((F_LO + FADE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = ((4 * SB + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 750;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int FRAMES_PER_MIX = 6;
    localparam logic [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};
    localparam logic [FADE_BITS-1:0] F_ONE = FADE_BITS'(FADE_ONE);

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // coef_index, coef_value, in_w, in_y, in_z, in_x, fade, zero fill
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    // command
    logic [CMD_BITS-1:0] s_axis_tuser = CMD_LOAD;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // out_w, out_y, out_z, out_x, zero fill
    logic [OUT_BITS-1:0] m_axis_tdata;

    int errors;
    int pending;
    int results;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int sender_mix [4] = '{0, 85, 0, 13};
    int receiver_mix [4] = '{0, 0, 85, 13};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    foa_rotation_crossfade i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    foa_rot_checker #(
        .IN_BITS  (IN_BITS),
        .OUT_BITS (OUT_BITS)
    ) i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [IN_BITS-1:0] pack_item(logic [IDX_BITS-1:0] idx,
                                                      logic [CB-1:0] coef,
                                                      logic [SB-1:0] w, logic [SB-1:0] y,
                                                      logic [SB-1:0] z, logic [SB-1:0] x,
                                                      logic [FADE_BITS-1:0] fade);
        logic [IN_BITS-1:0] d;
        d = '0;
        d[0 +: IDX_BITS]       = idx;
        d[IDX_BITS +: CB]      = coef;
        d[W_LO +: SB]          = w;
        d[W_LO + SB +: SB]     = y;
        d[W_LO + 2 * SB +: SB] = z;
        d[W_LO + 3 * SB +: SB] = x;
        d[F_LO +: FADE_BITS]   = fade;
        return d;
    endfunction

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(7))
            0: return S_MAX;
            1: return S_MIN;
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [FADE_BITS-1:0] rand_fade();
        case ($urandom_range(7))
            0: return '0;
            1: return F_ONE;
            2: return FADE_BITS'($urandom_range(65535, FADE_ONE + 1));
            default: return FADE_BITS'($urandom_range(FADE_ONE));
        endcase
    endfunction

    function automatic logic [CB-1:0] rand_coef();
        if ($urandom_range(7) == 0) return CB'($urandom);
        return CB'($urandom_range(32768) - 16384);
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [IN_BITS-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic load_coef(input int idx, input logic [CB-1:0] coef);
        send_item(CMD_LOAD, pack_item(IDX_BITS'(idx), coef, '0, '0, '0, '0, '0));
    endtask

    task automatic send_sample(input logic [SB-1:0] w, input logic [SB-1:0] y,
                               input logic [SB-1:0] z, input logic [SB-1:0] x,
                               input logic [FADE_BITS-1:0] fade);
        send_item(CMD_SAMPLE, pack_item('0, '0, w, y, z, x, fade));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int useful;
        int frame_no;
        int mix;
        logic [IDX_BITS-1:0] idx;
        t_cmd cmd;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The all-zero matrix after reset, then a matrix with the coefficient extremes.
        send_sample(S_MAX, S_MAX, S_MIN, S_MAX, F_ONE);
        load_coef(0, 16'sh7FFF);
        load_coef(1, 16'sh8000);
        load_coef(2, 16'sd16384);
        load_coef(3, -16'sd16384);
        load_coef(4, 16'sd16384);
        load_coef(5, 16'sd1);
        load_coef(6, 16'sd0);
        load_coef(7, -16'sd1);
        load_coef(8, 16'sd16384);
        send_item(CMD_BEGIN, '0);
        send_sample(S_MAX, S_MAX, S_MAX, S_MAX, F_ONE);
        send_sample(S_MIN, S_MIN, S_MIN, S_MIN, '0);
        send_sample(rand_sample(), S_MAX, S_MIN, S_MAX, 16'hFFFF);
        // Loads past the last coefficient are dropped.
        load_coef(9, 16'sh1234);
        load_coef(15, 16'shFFFF);
        load_coef(0, -16'sd16384);
        // A second begin must leave the previous matrix alone.
        send_item(CMD_BEGIN, '0);
        send_sample(S_MAX, S_MIN, S_MAX, S_MIN, '0);
        send_sample(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 16'd16384);
        send_item(CMD_END, '0);
        send_sample(S_MAX, S_MAX, S_MIN, S_MAX, '0);
        send_sample(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 16'd1);
        wait_for_results();

        useful = 0;
        frame_no = 0;
        while (useful < RANDOM_ITEMS) begin
            if (frame_no % FRAMES_PER_MIX == 0) begin
                wait_for_results();
                mix = (frame_no / FRAMES_PER_MIX) % 4;
                idle_pct  = sender_mix[mix];
                stall_pct = receiver_mix[mix];
            end
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(4, 1)) begin
                    cmd = t_cmd'($urandom_range(3));
                    idx = IDX_BITS'($urandom_range(15));
                    send_item(cmd, pack_item(idx, CB'($urandom), SB'($urandom), SB'($urandom),
                                             SB'($urandom), SB'($urandom),
                                             FADE_BITS'($urandom)));
                    if (!(cmd == CMD_LOAD && idx >= NUM_COEF)) useful++;
                end
            end else begin
                if ($urandom_range(7) != 0) begin
                    send_item(CMD_BEGIN, '0);
                    useful++;
                end
                repeat ($urandom_range(6)) begin
                    idx = ($urandom_range(15) == 0) ? IDX_BITS'($urandom_range(15, NUM_COEF))
                                                    : IDX_BITS'($urandom_range(NUM_COEF - 1));
                    load_coef(int'(idx), rand_coef());
                    if (idx < NUM_COEF) useful++;
                end
                repeat ($urandom_range(8, 1)) begin
                    send_sample(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                                rand_fade());
                    useful++;
                end
                if ($urandom_range(7) != 0) begin
                    send_item(CMD_END, '0);
                    useful++;
                end
            end
            frame_no++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d input transfers over %0d random frames; checked %0d rotated samples.",
                 items_sent, frame_no, results);
        $display("Covered coefficient loads, frame copies, fade clamping and saturation %s",
                 "under four idle and stall mixes.");
        if (pending != 0) begin
            $display("%0t: %0d rotated samples expected, none more received", $time, pending);
        end
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
